// File: rtl/bspline_kernel_value_and_integral_core_assert.svh
// Assertion macros used by the checker of the spline kernel core.
`ifndef BSPLINE_KERNEL_VALUE_AND_INTEGRAL_CORE_ASSERT_SVH
`define BSPLINE_KERNEL_VALUE_AND_INTEGRAL_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and off during reset.
`define BKVI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and off during reset.
`define BKVI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bkvi_pkg.sv
// Shared types, constants and control structures of the spline kernel core.
`default_nettype none

package bkvi_pkg;

  // Fixed field widths of the transaction payload.
  localparam int DATA_W = 48;
  localparam int HALF_W = DATA_W / 2;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 7;
  localparam int CFG_W  = 4;

  // Parameter defaults.
  localparam int DEF_MAX_ORDER = 8;
  localparam int DEF_FRAC_BITS = 32;

  // Spline order after reset.
  localparam logic [CFG_W-1:0] ORDER_RESET = CFG_W'(4);

  // Saturation limits of a 48-bit signed value.
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Command codes of an input transaction.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_KERNEL   = 2'd0,
    CMD_LOAD_PRIM     = 2'd1,
    CMD_EVAL_VALUE    = 2'd2,
    CMD_EVAL_INTEGRAL = 2'd3
  } cmd_e;

  // Source of the working result register.
  typedef enum logic [2:0] {
    RES_KEEP,
    RES_ZERO,
    RES_ONE,
    RES_HORNER,
    RES_SUM
  } res_sel_e;

  // Evaluation point of one Horner pass.
  typedef enum logic [1:0] {
    PT_LO,
    PT_HI,
    PT_KLO,
    PT_KHI
  } point_sel_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLAMP,
    ST_RANGE,
    ST_H_READ,
    ST_H_INIT,
    ST_H_SETUP,
    ST_H_MUL,
    ST_H_ROUND,
    ST_H_ADD,
    ST_H_DONE,
    ST_SUM,
    ST_FINAL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       mem_wr;
    logic       swap;
    logic       clamp;
    logic       acc_clear;
    logic       rd_en;
    logic       hinit;
    logic       xop_load;
    point_sel_e psel;
    logic       mul_setup;
    logic       mul_step;
    logic [1:0] mul_phase;
    logic       round;
    logic       hadd;
    logic       acc_add;
    logic       acc_sub;
    res_sel_e   res_sel;
    logic       load_out;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic in_support;
    logic range_empty;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/bkvi_ctrl.sv
// Sequencing controller: order register, loop counters and handshakes.
`default_nettype none

module bkvi_ctrl
  import bkvi_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  localparam int NW = $clog2(MAX_ORDER + 1),
  localparam int CW = $clog2(MAX_ORDER + 2),
  localparam int PDEPTH = MAX_ORDER * (MAX_ORDER + 1),
  localparam int AW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire dp_status_t       status_i,
  input  wire logic [NW-1:0]    j_value_i,
  input  wire logic [NW-1:0]    j_lo_i,
  input  wire logic [NW-1:0]    j_hi_i,
  output dp_ctrl_t              ctrl_o,
  output logic [NW-1:0]         n_o,
  output logic [NW-1:0]         j_o,
  output logic [AW-1:0]         addr_o
);

  state_e           state_q, state_d;
  logic [CFG_W-1:0] order_q;
  logic             out_valid_q, out_valid_d;
  logic             is_value_q, is_value_d;
  logic             upper_q, upper_d;
  logic [NW-1:0]    j_q, j_d;
  logic [NW-1:0]    jlo_q, jlo_d;
  logic [NW-1:0]    jhi_q, jhi_d;
  logic [AW-1:0]    base_q, base_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    i_q, i_d;
  logic [1:0]       ph_q, ph_d;
  logic [NW-1:0]    n;

  // Effective order: zero acts as one, anything above the maximum is clipped.
  always_comb begin
    if (order_q == '0) begin
      n = NW'(1);
    end else if (int'(order_q) > MAX_ORDER) begin
      n = NW'(MAX_ORDER);
    end else begin
      n = NW'(order_q);
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      is_value_q  <= 1'b0;
      upper_q     <= 1'b0;
      j_q         <= '0;
      jlo_q       <= '0;
      jhi_q       <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      ph_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      is_value_q  <= is_value_d;
      upper_q     <= upper_d;
      j_q         <= j_d;
      jlo_q       <= jlo_d;
      jhi_q       <= jhi_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      ph_q        <= ph_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    is_value_d  = is_value_q;
    upper_d     = upper_q;
    j_d         = j_q;
    jlo_d       = jlo_q;
    jhi_d       = jhi_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    ph_d        = ph_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    addr_o      = base_q + AW'(i_q - CW'(1));

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_DECODE;
        end
      end

      ST_DECODE: begin
        case (status_i.cmd)
          CMD_LOAD_KERNEL, CMD_LOAD_PRIM: begin
            ctrl_o.mem_wr  = 1'b1;
            ctrl_o.res_sel = RES_ZERO;
            state_d        = ST_FINAL;
          end
          CMD_EVAL_VALUE: begin
            is_value_d = 1'b1;
            if (!status_i.in_support) begin
              ctrl_o.res_sel = RES_ZERO;
              state_d        = ST_FINAL;
            end else if (n == NW'(1)) begin
              ctrl_o.res_sel = RES_ONE;
              state_d        = ST_FINAL;
            end else begin
              j_d     = j_value_i;
              base_d  = AW'(AW'(j_value_i) * AW'(n));
              cnt_d   = CW'(n);
              state_d = ST_H_READ;
            end
          end
          CMD_EVAL_INTEGRAL: begin
            is_value_d  = 1'b0;
            ctrl_o.swap = 1'b1;
            state_d     = ST_CLAMP;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_CLAMP: begin
        ctrl_o.clamp     = 1'b1;
        ctrl_o.acc_clear = 1'b1;
        state_d          = ST_RANGE;
      end

      // First and last interval of the clamped range.
      ST_RANGE: begin
        if (status_i.range_empty) begin
          ctrl_o.res_sel = RES_ZERO;
          state_d        = ST_FINAL;
        end else begin
          j_d     = j_lo_i;
          jlo_d   = j_lo_i;
          jhi_d   = j_hi_i;
          base_d  = AW'(AW'(j_lo_i) * (AW'(n) + AW'(1)));
          cnt_d   = CW'(n) + CW'(1);
          upper_d = 1'b1;
          state_d = ST_H_READ;
        end
      end

      // Fetch the leading coefficient of this polynomial.
      ST_H_READ: begin
        ctrl_o.rd_en = 1'b1;
        addr_o       = base_q + AW'(cnt_q - CW'(1));
        i_d          = cnt_q - CW'(1);
        state_d      = ST_H_INIT;
      end

      ST_H_INIT: begin
        ctrl_o.hinit    = 1'b1;
        ctrl_o.xop_load = 1'b1;
        if (is_value_q) begin
          ctrl_o.psel = PT_LO;
        end else if (upper_q) begin
          ctrl_o.psel = (j_q == jhi_q) ? PT_HI : PT_KHI;
        end else begin
          ctrl_o.psel = (j_q == jlo_q) ? PT_LO : PT_KLO;
        end
        state_d = ST_H_SETUP;
      end

      // One Horner step: fetch the next coefficient, start the product.
      ST_H_SETUP: begin
        ctrl_o.mul_setup = 1'b1;
        ctrl_o.rd_en     = 1'b1;
        ph_d             = '0;
        state_d          = ST_H_MUL;
      end

      ST_H_MUL: begin
        ctrl_o.mul_step  = 1'b1;
        ctrl_o.mul_phase = ph_q;
        ph_d             = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          state_d = ST_H_ROUND;
        end
      end

      ST_H_ROUND: begin
        ctrl_o.round = 1'b1;
        state_d      = ST_H_ADD;
      end

      ST_H_ADD: begin
        ctrl_o.hadd = 1'b1;
        if (i_q == CW'(1)) begin
          state_d = ST_H_DONE;
        end else begin
          i_d     = i_q - CW'(1);
          state_d = ST_H_SETUP;
        end
      end

      // Polynomial finished: deliver it or fold it into the integral.
      ST_H_DONE: begin
        if (is_value_q) begin
          ctrl_o.res_sel = RES_HORNER;
          state_d        = ST_FINAL;
        end else if (upper_q) begin
          ctrl_o.acc_add = 1'b1;
          upper_d        = 1'b0;
          state_d        = ST_H_READ;
        end else begin
          ctrl_o.acc_sub = 1'b1;
          if (j_q == jhi_q) begin
            state_d = ST_SUM;
          end else begin
            j_d     = j_q + NW'(1);
            base_d  = base_q + AW'(n) + AW'(1);
            upper_d = 1'b1;
            state_d = ST_H_READ;
          end
        end
      end

      ST_SUM: begin
        ctrl_o.res_sel = RES_SUM;
        state_d        = ST_FINAL;
      end

      // Hand the result to the output register once it is free.
      ST_FINAL: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load_out = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign n_o         = n;
  assign j_o         = j_q;

endmodule

`default_nettype wire

// File: rtl/bkvi_datapath.sv
// Datapath: coefficient memories, shared multiplier, Horner and integral registers.
`default_nettype none

module bkvi_datapath
  import bkvi_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int NW = $clog2(MAX_ORDER + 1),
  localparam int KDEPTH = MAX_ORDER * MAX_ORDER,
  localparam int PDEPTH = MAX_ORDER * (MAX_ORDER + 1),
  localparam int KAW = (KDEPTH > 1) ? $clog2(KDEPTH) : 1,
  localparam int AW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1,
  localparam int SUM_W = DATA_W + $clog2(MAX_ORDER) + 2
) (
  input  wire logic                     clk_i,
  input  wire logic [CMD_W-1:0]         command_i,
  input  wire logic [IDX_W-1:0]         coef_index_i,
  input  wire logic signed [DATA_W-1:0] coef_value_i,
  input  wire logic signed [DATA_W-1:0] x_first_i,
  input  wire logic signed [DATA_W-1:0] x_second_i,
  input  wire dp_ctrl_t                 ctrl_i,
  input  wire logic [NW-1:0]            n_i,
  input  wire logic [NW-1:0]            j_i,
  input  wire logic [AW-1:0]            addr_i,
  output dp_status_t                    status_o,
  output logic [NW-1:0]                 j_value_o,
  output logic [NW-1:0]                 j_lo_o,
  output logic [NW-1:0]                 j_hi_o,
  output logic signed [DATA_W-1:0]      result_value_o
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(Q_MIN);
  localparam logic [PROD_W-1:0]       RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [DATA_W-1:0]       LIM_POS = DATA_W'(Q_MAX);
  localparam logic [DATA_W-1:0]       LIM_NEG = DATA_W'(Q_MIN);

  // Clamp a wide signed value into the 48-bit range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] val);
    logic signed [DATA_W-1:0] res;
    if (val > SUM_MAX) begin
      res = Q_MAX;
    end else if (val < SUM_MIN) begin
      res = Q_MIN;
    end else begin
      res = DATA_W'(val);
    end
    return res;
  endfunction

  cmd_e                     cmd_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [DATA_W-1:0] cval_q;
  logic signed [DATA_W-1:0] xa_q;
  logic signed [DATA_W-1:0] xb_q;
  logic                     bneg_q;
  logic signed [DATA_W-1:0] kmem [KDEPTH];
  logic signed [DATA_W-1:0] pmem [PDEPTH];
  logic signed [DATA_W-1:0] krd_q;
  logic signed [DATA_W-1:0] prd_q;
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] v_q;
  logic signed [DATA_W-1:0] xop_q;
  logic [DATA_W-1:0]        ma_q;
  logic [DATA_W-1:0]        mb_q;
  logic                     mneg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [DATA_W-1:0]        qmag_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] res_q;
  logic signed [DATA_W-1:0] out_q;

  logic [NW-1:0]            half_n;
  logic [NW-1:0]            hi_end;
  logic signed [DATA_W-1:0] qlo;
  logic signed [DATA_W-1:0] qhi;
  logic [NW-1:0]            j_hi_raw;
  logic signed [NW+1:0]     k_lo;
  logic signed [NW+1:0]     k_hi;
  logic signed [DATA_W-1:0] kpt_lo;
  logic signed [DATA_W-1:0] kpt_hi;
  logic signed [DATA_W-1:0] point;
  logic [HALF_W-1:0]        a_part;
  logic [HALF_W-1:0]        b_part;
  logic [DATA_W-1:0]        pp;
  logic [PROD_W-1:0]        pp_shifted;
  logic [PROD_W-1:0]        rnd;
  logic [PROD_W-1:0]        qfull;
  logic [DATA_W-1:0]        qlimit;
  logic signed [DATA_W:0]   hsum;
  logic signed [SUM_W-1:0]  sum_signed;

  // Support ends of the current order in Q format.
  assign half_n = n_i >> 1;
  assign hi_end = n_i - half_n;
  assign qlo    = -($signed(DATA_W'(half_n)) <<< FRAC_BITS);
  assign qhi    = $signed(DATA_W'(hi_end) << FRAC_BITS);

  // Status for the controller: support test, interval numbers, empty range.
  assign status_o.cmd         = cmd_q;
  assign status_o.in_support  = (xa_q > qlo) && (xa_q < qhi);
  assign status_o.range_empty = !(xa_q < xb_q);
  assign j_value_o            = xa_q[FRAC_BITS +: NW] + half_n;
  assign j_lo_o               = xa_q[FRAC_BITS +: NW] + half_n;
  assign j_hi_raw             = xb_q[FRAC_BITS +: NW] + half_n;
  assign j_hi_o               = (j_hi_raw == n_i) ? (n_i - NW'(1)) : j_hi_raw;

  // Transaction capture, bound ordering and clamping.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= cmd_e'(command_i);
      idx_q  <= coef_index_i;
      cval_q <= coef_value_i;
      xa_q   <= x_first_i;
      xb_q   <= x_second_i;
    end else if (ctrl_i.swap) begin
      if (xb_q < xa_q) begin
        xa_q   <= xb_q;
        xb_q   <= xa_q;
        bneg_q <= 1'b1;
      end else begin
        bneg_q <= 1'b0;
      end
    end else if (ctrl_i.clamp) begin
      if (xa_q < qlo) begin
        xa_q <= qlo;
      end
      if (xb_q > qhi) begin
        xb_q <= qhi;
      end
    end
  end

  // Kernel coefficient memory.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && (cmd_q == CMD_LOAD_KERNEL) && (int'(idx_q) < KDEPTH)) begin
      kmem[KAW'(idx_q)] <= cval_q;
    end
    if (ctrl_i.rd_en) begin
      krd_q <= kmem[KAW'(addr_i)];
    end
  end

  // Antiderivative coefficient memory.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr && (cmd_q == CMD_LOAD_PRIM) && (int'(idx_q) < PDEPTH)) begin
      pmem[AW'(idx_q)] <= cval_q;
    end
    if (ctrl_i.rd_en) begin
      prd_q <= pmem[addr_i];
    end
  end

  assign rdata = (cmd_q == CMD_EVAL_VALUE) ? krd_q : prd_q;

  // Evaluation point: a bound or an interval edge.
  assign k_lo   = $signed({2'b00, j_i}) - $signed({2'b00, half_n});
  assign k_hi   = k_lo + $signed((NW + 2)'(1));
  assign kpt_lo = DATA_W'(k_lo) <<< FRAC_BITS;
  assign kpt_hi = DATA_W'(k_hi) <<< FRAC_BITS;

  always_comb begin
    case (ctrl_i.psel)
      PT_LO:   point = xa_q;
      PT_HI:   point = xb_q;
      PT_KLO:  point = kpt_lo;
      PT_KHI:  point = kpt_hi;
      default: point = xa_q;
    endcase
  end

  // One 24 by 24 partial product per cycle, placed by phase.
  assign a_part = ctrl_i.mul_phase[0] ? ma_q[DATA_W-1:HALF_W] : ma_q[HALF_W-1:0];
  assign b_part = ctrl_i.mul_phase[1] ? mb_q[DATA_W-1:HALF_W] : mb_q[HALF_W-1:0];
  assign pp     = a_part * b_part;

  always_comb begin
    case (ctrl_i.mul_phase)
      2'd0:    pp_shifted = PROD_W'(pp);
      2'd3:    pp_shifted = PROD_W'(pp) << (2 * HALF_W);
      default: pp_shifted = PROD_W'(pp) << HALF_W;
    endcase
  end

  // Round to nearest, ties away from zero, and limit the magnitude.
  assign rnd    = prod_q + RND_HALF;
  assign qfull  = rnd >> FRAC_BITS;
  assign qlimit = mneg_q ? LIM_NEG : LIM_POS;

  // Add the next coefficient, applying the product sign as add or subtract.
  assign hsum = mneg_q ? ($signed({rdata[DATA_W-1], rdata}) - $signed({1'b0, qmag_q}))
                       : ($signed({rdata[DATA_W-1], rdata}) + $signed({1'b0, qmag_q}));

  assign sum_signed = bneg_q ? -sum_q : sum_q;

  // Horner, multiplier and integral registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.hinit) begin
      v_q <= rdata;
    end else if (ctrl_i.hadd) begin
      v_q <= sat_data(SUM_W'(hsum));
    end
    if (ctrl_i.xop_load) begin
      xop_q <= point;
    end
    if (ctrl_i.mul_setup) begin
      ma_q   <= v_q[DATA_W-1] ? DATA_W'(-v_q) : DATA_W'(v_q);
      mb_q   <= xop_q[DATA_W-1] ? DATA_W'(-xop_q) : DATA_W'(xop_q);
      mneg_q <= v_q[DATA_W-1] ^ xop_q[DATA_W-1];
      prod_q <= '0;
    end else if (ctrl_i.mul_step) begin
      prod_q <= prod_q + pp_shifted;
    end
    if (ctrl_i.round) begin
      qmag_q <= (qfull > PROD_W'(qlimit)) ? qlimit : qfull[DATA_W-1:0];
    end
    if (ctrl_i.acc_clear) begin
      sum_q <= '0;
    end else if (ctrl_i.acc_add) begin
      sum_q <= sum_q + SUM_W'(v_q);
    end else if (ctrl_i.acc_sub) begin
      sum_q <= sum_q - SUM_W'(v_q);
    end
  end

  // Working result and output register.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.res_sel)
      RES_ZERO:   res_q <= '0;
      RES_ONE:    res_q <= $signed(DATA_W'(1) << FRAC_BITS);
      RES_HORNER: res_q <= v_q;
      RES_SUM:    res_q <= sat_data(sum_signed);
      default:    res_q <= res_q;
    endcase
    if (ctrl_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign result_value_o = out_q;

endmodule

`default_nettype wire

// File: rtl/bspline_kernel_value_and_integral_core.sv
// Top level of the centred spline kernel value and integral core.
`default_nettype none

// Evaluates a centred spline kernel of the configured order, or its definite
// integral, from two coefficient memories that load transactions fill. Every
// input transaction gives exactly one result; load transactions return zero.
// One transaction is in work at a time, and the next is accepted while a
// finished result still waits in the output register. The Horner products run
// on one shared 24 by 24 multiplier: a Horner step sets up the operands, forms
// four partial products, rounds and adds the next coefficient. An integral
// runs two Horner passes for every unit interval. A value outside the support
// or at order one, and an empty clamped range, need no Horner pass. The result
// is loaded into the output register in the cycle before the core can accept
// again. If the previous result has not been taken by then, the core waits for
// it with its input held off. The spline order register may only be written
// while the core is idle.
module bspline_kernel_value_and_integral_core
  import bkvi_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int NW = $clog2(MAX_ORDER + 1),
  localparam int PDEPTH = MAX_ORDER * (MAX_ORDER + 1),
  localparam int AW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [CMD_W-1:0]         command_i,
  input  wire logic [IDX_W-1:0]         coef_index_i,
  input  wire logic signed [DATA_W-1:0] coef_value_i,
  input  wire logic signed [DATA_W-1:0] x_first_i,
  input  wire logic signed [DATA_W-1:0] x_second_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      result_value_o
);

  dp_ctrl_t      ctrl;
  dp_status_t    status;
  logic [NW-1:0] n;
  logic [NW-1:0] j;
  logic [NW-1:0] j_value;
  logic [NW-1:0] j_lo;
  logic [NW-1:0] j_hi;
  logic [AW-1:0] addr;

  // Controller.
  bkvi_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .j_value_i   (j_value),
    .j_lo_i      (j_lo),
    .j_hi_i      (j_hi),
    .ctrl_o      (ctrl),
    .n_o         (n),
    .j_o         (j),
    .addr_o      (addr)
  );

  // Datapath.
  bkvi_datapath #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .command_i      (command_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .x_first_i      (x_first_i),
    .x_second_i     (x_second_i),
    .ctrl_i         (ctrl),
    .n_i            (n),
    .j_i            (j),
    .addr_i         (addr),
    .status_o       (status),
    .j_value_o      (j_value),
    .j_lo_o         (j_lo),
    .j_hi_o         (j_hi),
    .result_value_o (result_value_o)
  );

endmodule

`default_nettype wire

// File: rtl/bkvi_checker.sv
// Port-level checker of the spline kernel core and its bind statement.
`default_nettype none

`include "bspline_kernel_value_and_integral_core_assert.svh"

module bkvi_checker
  import bkvi_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [DATA_W-1:0] result_value_o
);

  // The core works on one transaction at a time, so it is busy right after accepting.
  `BKVI_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

  // No result can appear in the cycle that follows an accepted transaction.
  `BKVI_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_o, !$rose(out_valid_o), "result too early")

  // A new result is only raised out of a busy cycle.
  `BKVI_ASSERT_IMPL(a_result_from_busy, $rose(out_valid_o), $past(!in_ready_o), "result while idle")

  // A waiting result holds until it is taken.
  `BKVI_ASSERT_NEXT(a_result_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o), "result dropped")

endmodule

bind bspline_kernel_value_and_integral_core bkvi_checker u_bkvi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the centred spline kernel value and integral core.
`timescale 1ns / 1ps

module tb;
  import bkvi_pkg::*;

  localparam int     MAX_ORDER    = DEF_MAX_ORDER;
  localparam int     FRAC         = DEF_FRAC_BITS;
  localparam int     KDEPTH       = MAX_ORDER * MAX_ORDER;
  localparam int     PDEPTH       = MAX_ORDER * (MAX_ORDER + 1);
  localparam longint ONE_Q        = longint'(1) << FRAC;
  localparam int     RANDOM_ITEMS = 1050;
  localparam int     LONG_HOLD_AT = 500;
  localparam int     LONG_HOLD    = 400;
  localparam int     DRAIN_LIMIT  = 20000;
  localparam int     TAIL_CYCLES  = 1000;

  typedef logic signed [DATA_W-1:0] q_t;

  // Keeps its own copy of the order register and both coefficient tables, works out
  // the expected result of every accepted transaction and compares the results.
  class kernel_result_checker;
    logic [CFG_W-1:0] order_reg;
    q_t               kern_coef [KDEPTH];
    q_t               prim_coef [PDEPTH];
    q_t               expected_values [$];
    cmd_e             expected_cmds [$];
    int               fail_count;
    int               compared;
    int               cmd_count [4];

    function new();
      order_reg = ORDER_RESET;
      foreach (kern_coef[i]) kern_coef[i] = '0;
      foreach (prim_coef[i]) prim_coef[i] = '0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      fail_count = 0;
      compared   = 0;
    endfunction

    function void write_order(logic [CFG_W-1:0] value);
      order_reg = value;
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    task report_fault(string msg);
      fail_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function longint sat_q(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
    endfunction

    // Product scaled down by the fraction bits, rounded half away from zero, saturated.
    function longint round_mul(longint a, longint b);
      logic [95:0] ma;
      logic [95:0] mb;
      logic [95:0] q;
      logic [95:0] limit;
      bit          neg;
      neg   = (a < 0) != (b < 0);
      ma    = (a < 0) ? 96'(-a) : 96'(a);
      mb    = (b < 0) ? 96'(-b) : 96'(b);
      q     = (ma * mb + (96'd1 << (FRAC - 1))) >> FRAC;
      limit = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
      if (q > limit) q = limit;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint coef_at(bit from_prim, int idx);
      if (from_prim) return (idx >= 0 && idx < PDEPTH) ? longint'(prim_coef[idx]) : 0;
      return (idx >= 0 && idx < KDEPTH) ? longint'(kern_coef[idx]) : 0;
    endfunction

    // Horner's rule over count coefficients starting at base, in absolute x.
    function longint horner_at(bit from_prim, int base, int count, longint x);
      longint acc;
      acc = coef_at(from_prim, base + count - 1);
      for (int i = count - 1; i >= 1; i--)
        acc = sat_q(round_mul(acc, x) + coef_at(from_prim, base + i - 1));
      return acc;
    endfunction

    // Antiderivative difference over [a, b] within unit interval k.
    function longint prim_span(int n, int lo_end, longint k, longint a, longint b);
      int base;
      base = int'(k - lo_end) * (n + 1);
      return horner_at(1'b1, base, n + 1, b) - horner_at(1'b1, base, n + 1, a);
    endfunction

    function q_t predict_spline_result(cmd_e cmd, logic [IDX_W-1:0] idx, q_t coef,
                                       q_t xa, q_t xb);
      int     n;
      int     lo_end;
      int     hi_end;
      longint qlo;
      longint qhi;
      longint x;
      longint a;
      longint b;
      longint t;
      longint k1;
      longint k2;
      longint sum;
      longint res;
      bit     flip;
      n = int'(order_reg);
      if (n < 1) n = 1;
      if (n > MAX_ORDER) n = MAX_ORDER;
      lo_end = -(n / 2);
      hi_end = n - n / 2;
      qlo    = longint'(lo_end) * ONE_Q;
      qhi    = longint'(hi_end) * ONE_Q;
      res    = 0;
      flip   = 1'b0;
      case (cmd)
        CMD_LOAD_KERNEL: begin
          if (idx < KDEPTH) kern_coef[idx] = coef;
        end
        CMD_LOAD_PRIM: begin
          if (idx < PDEPTH) prim_coef[idx] = coef;
        end
        CMD_EVAL_VALUE: begin
          x = longint'(xa);
          // Zero outside the open support, exactly one inside it for order one.
          if (x > qlo && x < qhi) begin
            if (n == 1) res = ONE_Q;
            else res = horner_at(1'b0, int'((x >>> FRAC) - lo_end) * n, n, x);
          end
        end
        default: begin
          a = longint'(xa);
          b = longint'(xb);
          if (b < a) begin
            t    = a;
            a    = b;
            b    = t;
            flip = 1'b1;
          end
          if (a < qlo) a = qlo;
          if (b > qhi) b = qhi;
          // An empty clamped range leaves the result at zero.
          if (a < b) begin
            k1 = a >>> FRAC;
            k2 = b >>> FRAC;
            if (k2 == hi_end) k2--;
            if (k1 == k2) begin
              sum = prim_span(n, lo_end, k1, a, b);
            end else begin
              sum = prim_span(n, lo_end, k1, a, (k1 + 1) * ONE_Q);
              for (longint k = k1 + 1; k < k2; k++)
                sum += prim_span(n, lo_end, k, k * ONE_Q, (k + 1) * ONE_Q);
              sum += prim_span(n, lo_end, k2, k2 * ONE_Q, b);
            end
            res = sat_q(flip ? -sum : sum);
          end
        end
      endcase
      return res[DATA_W-1:0];
    endfunction

    task note_command(cmd_e cmd, logic [IDX_W-1:0] idx, q_t coef, q_t xa, q_t xb);
      expected_values.push_back(predict_spline_result(cmd, idx, coef, xa, xb));
      expected_cmds.push_back(cmd);
      cmd_count[cmd]++;
    endtask

    task check_value(q_t got);
      q_t   want;
      cmd_e cmd;
      if (expected_values.size() == 0) begin
        report_fault($sformatf("result_value %0d arrived with nothing outstanding", got));
        return;
      end
      want = expected_values.pop_front();
      cmd  = expected_cmds.pop_front();
      compared++;
      if (got !== want)
        report_fault($sformatf("%s result_value got %0d, expected %0d",
                               cmd.name(), got, want));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [CMD_W-1:0]        command_i;
  logic [IDX_W-1:0]        coef_index_i;
  q_t                      coef_value_i;
  q_t                      x_first_i;
  q_t                      x_second_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  q_t                      result_value_o;

  kernel_result_checker    sb;
  logic [CFG_W-1:0]        cur_order;
  bit                      tx_burst;
  int                      order_writes;

  bspline_kernel_value_and_integral_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .x_first_i      (x_first_i),
    .x_second_i     (x_second_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch the ports at every rising edge: register writes, accepted transactions
  // and returned results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_order(cfg_wdata_i);
      if (in_valid_i && in_ready_o)
        sb.note_command(cmd_e'(command_i), coef_index_i, coef_value_i, x_first_i,
                        x_second_i);
      if (out_valid_o && out_ready_i) sb.check_value(result_value_o);
    end
  end

  // Result side: random back-pressure, stretches without it, and one long hold-off.
  initial begin : result_sink
    int unsigned wait_cycles;
    int          accepted;
    bit          rx_burst;
    out_ready_i = 1'b0;
    accepted    = 0;
    rx_burst    = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (accepted % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (accepted == LONG_HOLD_AT) wait_cycles = LONG_HOLD;
      else wait_cycles = rx_burst ? 0 : $urandom_range(0, 12);
      if (wait_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      accepted++;
      @(negedge clk_i);
    end
  end

  // Effective order as the core sees it.
  function automatic int eff_order(logic [CFG_W-1:0] ord);
    if (ord < 1) return 1;
    if (ord > MAX_ORDER) return MAX_ORDER;
    return int'(ord);
  endfunction

  function automatic q_t q_quarters(int quarters);
    return DATA_W'(longint'(quarters) * (ONE_Q / 4));
  endfunction

  // A point mostly near the support, sometimes on whole numbers, the extremes or anywhere.
  function automatic q_t rand_point(int n);
    longint      lo;
    longint      span;
    logic [63:0] r;
    lo   = longint'(-(n / 2) - 1) * ONE_Q;
    span = longint'(n + 2) * ONE_Q;
    r    = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       return r[DATA_W-1:0];
      1:       return DATA_W'(lo + longint'($urandom_range(0, n + 2)) * ONE_Q);
      2:       return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      default: return DATA_W'(lo + longint'(r % 64'(span)));
    endcase
  endfunction

  // Coefficients are mostly within plus or minus two, so that results rarely saturate.
  function automatic q_t rand_coef();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       return r[DATA_W-1:0];
      1:       return Q_MAX;
      2:       return Q_MIN;
      default: return DATA_W'($signed(r[33:0]));
    endcase
  endfunction

  // Offer one transaction after a random gap and hold it until it is accepted.
  task automatic send_item(input cmd_e cmd, input logic [IDX_W-1:0] idx, input q_t coef,
                           input q_t xa, input q_t xb);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i    <= cmd;
    coef_index_i <= idx;
    coef_value_i <= coef;
    x_first_i    <= xa;
    x_second_i   <= xb;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // The order register is only written once every result has been handed over.
  task automatic apply_order(input logic [CFG_W-1:0] ord);
    wait_until_idle();
    cfg_wdata_i <= ord;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    cur_order = ord;
    order_writes++;
  endtask

  task automatic send_random_item();
    int               n;
    int unsigned      pick;
    logic [IDX_W-1:0] idx;
    q_t               a;
    q_t               b;
    n    = eff_order(cur_order);
    pick = $urandom_range(0, 9);
    idx  = IDX_W'($urandom_range(0, 127));
    if (pick < 2) begin
      // Loads land mostly inside the tables; the rest take any index, and those beyond the tables are ignored.
      if ($urandom_range(0, 3) != 0)
        idx = IDX_W'($urandom_range(0, (pick == 0) ? KDEPTH - 1 : PDEPTH - 1));
      send_item((pick == 0) ? CMD_LOAD_KERNEL : CMD_LOAD_PRIM, idx, rand_coef(),
                rand_point(n), rand_point(n));
    end else begin
      a = rand_point(n);
      b = ($urandom_range(0, 15) == 0) ? a : rand_point(n);
      send_item((pick < 6) ? CMD_EVAL_VALUE : CMD_EVAL_INTEGRAL, idx, rand_coef(), a, b);
    end
  endtask

  // Stimulus: table fill, directed corner cases, then random phases over several orders.
  initial begin : stimulus
    int phase_orders [11];
    int per_phase;
    int guard;
    sb           = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    command_i    = '0;
    coef_index_i = '0;
    coef_value_i = '0;
    x_first_i    = '0;
    x_second_i   = '0;
    cur_order    = ORDER_RESET;
    tx_burst     = 1'b0;
    order_writes = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Write every table entry once, so that no evaluation reads an unwritten entry.
    for (int i = 0; i < KDEPTH; i++)
      send_item(CMD_LOAD_KERNEL, IDX_W'(i), rand_coef(), rand_point(4), rand_point(4));
    for (int i = 0; i < PDEPTH; i++)
      send_item(CMD_LOAD_PRIM, IDX_W'(i), rand_coef(), rand_point(4), rand_point(4));

    // Directed part at the reset order of four: last table entries, loads past
    // the end of each table, and the extremes of the coefficient.
    send_item(CMD_LOAD_KERNEL, IDX_W'(KDEPTH - 1), Q_MAX, Q_MAX, Q_MIN);
    send_item(CMD_LOAD_KERNEL, IDX_W'(KDEPTH), Q_MIN, Q_MIN, Q_MAX);
    send_item(CMD_LOAD_PRIM, IDX_W'(PDEPTH - 1), Q_MIN, '0, '0);
    send_item(CMD_LOAD_PRIM, IDX_W'(PDEPTH), Q_MAX, '0, '0);
    send_item(CMD_LOAD_PRIM, '1, '1, '1, '1);
    // Values inside, on and just within the support ends, and far outside.
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(0), '0);
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(-8), '0);
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(8), '0);
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(-8) + 1, '0);
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(8) - 1, '0);
    send_item(CMD_EVAL_VALUE, '0, '0, Q_MAX, '0);
    send_item(CMD_EVAL_VALUE, '0, '0, Q_MIN, '0);
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(-2), '0);
    // Integrals: whole support, reversed bounds, empty ranges on either side, one
    // interval only, upper bound on the right support end, and equal bounds.
    send_item(CMD_EVAL_INTEGRAL, '0, '0, Q_MIN, Q_MAX);
    send_item(CMD_EVAL_INTEGRAL, '0, '0, Q_MAX, Q_MIN);
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(12), q_quarters(20));
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(-20), q_quarters(-12));
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(1), q_quarters(3));
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(0), q_quarters(8));
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(4), q_quarters(4));
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(6), q_quarters(-6));
    // Order one, and the out-of-range order zero that behaves as one.
    apply_order(CFG_W'(1));
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(2), '0);
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(4), '0);
    send_item(CMD_EVAL_INTEGRAL, '0, '0, q_quarters(-4), q_quarters(8));
    apply_order(CFG_W'(0));
    send_item(CMD_EVAL_VALUE, '0, '0, q_quarters(1), '0);

    // Random phases, each at its own order; the order write drains the core first.
    phase_orders = '{8, 2, 3, 5, 1, 6, 7, 12, 4, 15, 8};
    per_phase    = RANDOM_ITEMS / 11;
    foreach (phase_orders[p]) begin
      apply_order(CFG_W'(phase_orders[p]));
      for (int i = 0; i < per_phase; i++) begin
        if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
    end

    // Let every outstanding result come back, then allow the longest integral time.
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0)
      sb.report_fault($sformatf("%0d results never arrived", sb.pending()));

    $display("Run covered %0d kernel loads, %0d primitive loads, %0d values and %0d integrals",
             sb.cmd_count[CMD_LOAD_KERNEL], sb.cmd_count[CMD_LOAD_PRIM],
             sb.cmd_count[CMD_EVAL_VALUE], sb.cmd_count[CMD_EVAL_INTEGRAL]);
    $display("over %0d order settings; %0d results compared, %0d faults.",
             order_writes, sb.compared, sb.fail_count);
    if (sb.fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: bspline_kernel_value_and_integral_core.f
+incdir+rtl
rtl/bkvi_pkg.sv
rtl/bkvi_ctrl.sv
rtl/bkvi_datapath.sv
rtl/bspline_kernel_value_and_integral_core.sv
rtl/bkvi_checker.sv
tb/tb.sv
